// ----- hdl/hse_pkg.sv -----
`default_nettype none

package hse_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEAP_KIND  = 2'd0;
  localparam logic [1:0] REG_SORT_ORDER = 2'd1;
  localparam logic [1:0] REG_BUILD_ONLY = 2'd2;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;

  // Outcome of one sift-down comparison step.
  typedef struct packed {
    logic move;   // a child outranks the sifted value and moves up
    logic right;  // the right child is the one that moves
  } hse_pick_t;

  // True when a outranks b: greater for a max-heap, smaller for a min-heap.
  function automatic logic ranks_above(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b,
                                       input logic                     min_kind);
    ranks_above = min_kind ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hse_pick.sv -----
`default_nettype none

module hse_pick (
  input  wire logic [hse_pkg::DATA_W-1:0] carried,
  input  wire logic [hse_pkg::DATA_W-1:0] left_val,
  input  wire logic [hse_pkg::DATA_W-1:0] right_val,
  input  wire logic                       right_ok,
  input  wire logic                       min_kind,
  output hse_pkg::hse_pick_t              pick,
  output logic [hse_pkg::DATA_W-1:0]      child_val
);
  import hse_pkg::*;

  logic              left_above;
  logic              right_above;
  logic [DATA_W-1:0] best_val;

  // The left child is weighed against the sifted value first; the right
  // child must then beat whichever of the two won, so ties keep the left.
  always_comb begin
    left_above  = ranks_above($signed(left_val), $signed(carried), min_kind);
    best_val    = left_above ? left_val : carried;
    right_above = right_ok && ranks_above($signed(right_val), $signed(best_val), min_kind);
    pick.move   = left_above || right_above;
    pick.right  = right_above;
    child_val   = right_above ? right_val : left_val;
  end

endmodule

`default_nettype wire

// ----- hdl/heap_sort_engine.sv -----
// heap_sort_engine: heapsort of a set of signed 32-bit elements held in one
// on-chip memory of CAPACITY entries.
//
// Input channel (in_valid/in_ready, element, set_end): each transaction
// stores one element. The transaction with set_end high closes the set and
// starts the work. Elements beyond CAPACITY are discarded and every result
// of that set then shows dropped high.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// heap_kind, sort_order and build_only; it is always ready and is meant to
// be used while no set is in flight. Other indexes are ignored.
// Output channel (out_valid/out_ready): one transaction per stored element,
// with its position, final_flag on the last one and the sticky dropped flag.
//
// Loading accepts one element per cycle. Since the single memory reads
// synchronously, each sift-down level reads the children, then compares
// and writes back; each sift also has its setup and close states. Each
// result is read from the memory, then registered, so results never leave
// back to back. While the receiver stalls, the output register holds its
// transaction and the sequencer waits; after the last result is registered
// the block takes the next set at once. Reset empties the set and clears
// the configuration registers.
`default_nettype none

module heap_sort_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [hse_pkg::DATA_W-1:0] element,
  input  wire logic                              set_end,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic                              cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [hse_pkg::DATA_W-1:0]      value,
  output logic [hse_pkg::POS_W-1:0]              position,
  output logic                                   final_flag,
  output logic                                   dropped
);
  import hse_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = AW + 2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_BUILD_RD,
    S_BUILD_LD,
    S_SWAP_RD,
    S_SWAP_WR,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_SIFT_END,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state;

  // Element memory: one write port, two synchronous read ports.
  logic [DATA_W-1:0] mem [CAPACITY];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;

  logic              heap_kind;
  logic              sort_order;
  logic              build_only;

  logic [CW-1:0]     fill;
  logic              overflow;
  logic [CW-1:0]     idx;       // build root, or sort boundary
  logic              sorting;   // extraction phase once the heap is built
  logic [AW-1:0]     root;      // current hole of the sift-down
  logic [CW-1:0]     len;       // heap size of the current sift-down
  logic [DATA_W-1:0] carried;   // value being sifted down
  logic              right_ok;
  logic [CW-1:0]     emit_cnt;

  logic              in_fire;
  logic              has_room;
  logic [CW-1:0]     fill_next;
  logic [LW-1:0]     left_w;
  logic [LW-1:0]     right_w;
  logic              no_child;
  logic              reverse;
  logic [CW-1:0]     emit_addr;
  logic              emit_last;
  hse_pick_t         pick;
  logic [DATA_W-1:0] child_val;

  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign has_room  = (fill < CW'(CAPACITY));
  assign fill_next = has_room ? fill + CW'(1) : fill;

  // Children of the hole, kept wide enough to compare against the length.
  assign left_w   = {1'b0, root, 1'b1};
  assign right_w  = left_w + LW'(1);
  assign no_child = (left_w >= LW'(len));

  // A heapsort gives ascending order for a max-heap and descending order for
  // a min-heap; the other order is produced by reading the memory backwards.
  assign reverse   = !build_only && (heap_kind != sort_order);
  assign emit_addr = reverse ? (fill - CW'(1) - emit_cnt) : emit_cnt;
  assign emit_last = (emit_cnt + CW'(1) == fill);

  hse_pick u_pick (
    .carried   (carried),
    .left_val  (rdata_a),
    .right_val (rdata_b),
    .right_ok  (right_ok),
    .min_kind  (heap_kind),
    .pick      (pick),
    .child_val (child_val)
  );

  // Memory port control. A write never hits an entry whose read in the same
  // cycle is used, and a written entry's new value is needed no earlier than
  // the following cycle, so the store needs no bypass.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = root;
    wr_data   = carried;
    rd_addr_a = left_w[AW-1:0];
    rd_addr_b = right_w[AW-1:0];
    case (state)
      S_LOAD: begin
        wr_en   = in_fire && has_room;
        wr_addr = fill[AW-1:0];
        wr_data = element;
      end
      S_BUILD_RD: begin
        rd_addr_a = idx[AW-1:0];
      end
      S_SWAP_RD: begin
        rd_addr_a = '0;
        rd_addr_b = idx[AW-1:0];
      end
      S_SWAP_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rdata_a;
      end
      S_SIFT_RD: begin
        wr_en = no_child;
      end
      S_SIFT_CMP: begin
        wr_en   = 1'b1;
        wr_data = pick.move ? child_val : carried;
      end
      S_EMIT_RD: begin
        rd_addr_a = emit_addr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_a <= mem[rd_addr_a];
    rdata_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_kind  <= 1'b0;
      sort_order <= 1'b0;
      build_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEAP_KIND:  heap_kind  <= cfg_data;
        REG_SORT_ORDER: sort_order <= cfg_data;
        REG_BUILD_ONLY: build_only <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: load, bottom-up build, extraction unless build_only, then emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
      sorting   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            fill <= fill_next;
            if (!has_room) begin
              overflow <= 1'b1;
            end
            if (set_end) begin
              sorting  <= 1'b0;
              emit_cnt <= '0;
              if ((fill_next >> 1) == '0) begin
                state <= S_EMIT_RD;
              end else begin
                idx   <= (fill_next >> 1) - CW'(1);
                state <= S_BUILD_RD;
              end
            end
          end
        end
        S_BUILD_RD: begin
          state <= S_BUILD_LD;
        end
        S_BUILD_LD: begin
          carried <= rdata_a;
          root    <= idx[AW-1:0];
          len     <= fill;
          state   <= S_SIFT_RD;
        end
        S_SWAP_RD: begin
          state <= S_SWAP_WR;
        end
        S_SWAP_WR: begin
          // The old root went to the boundary; the boundary value is sifted
          // down from the top of the shrunken heap.
          carried <= rdata_b;
          root    <= '0;
          len     <= idx;
          state   <= S_SIFT_RD;
        end
        S_SIFT_RD: begin
          right_ok <= (right_w < LW'(len));
          state    <= no_child ? S_SIFT_END : S_SIFT_CMP;
        end
        S_SIFT_CMP: begin
          if (pick.move) begin
            root  <= pick.right ? right_w[AW-1:0] : left_w[AW-1:0];
            state <= S_SIFT_RD;
          end else begin
            state <= S_SIFT_END;
          end
        end
        S_SIFT_END: begin
          if (!sorting) begin
            if (idx != '0) begin
              idx   <= idx - CW'(1);
              state <= S_BUILD_RD;
            end else if (build_only) begin
              state <= S_EMIT_RD;
            end else begin
              sorting <= 1'b1;
              idx     <= fill - CW'(1);
              state   <= S_SWAP_RD;
            end
          end else if (idx == CW'(1)) begin
            state <= S_EMIT_RD;
          end else begin
            idx   <= idx - CW'(1);
            state <= S_SWAP_RD;
          end
        end
        S_EMIT_RD: begin
          // Read only when the output register is free by the next cycle.
          if (!out_valid || out_ready) begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          out_valid  <= 1'b1;
          value      <= $signed(rdata_a);
          position   <= POS_W'(emit_cnt);
          final_flag <= emit_last;
          dropped    <= overflow;
          if (emit_last) begin
            fill     <= '0;
            overflow <= 1'b0;
            state    <= S_LOAD;
          end else begin
            emit_cnt <= emit_cnt + CW'(1);
            state    <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hse_checker.sv -----
`default_nettype none

module hse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] value,
  input wire logic [4:0]  position,
  input wire logic        final_flag,
  input wire logic        dropped
);

  logic [4:0] expect_pos;
  logic       set_dropped;

  // Track where the next result of a set must land and the set's drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_pos  <= '0;
      set_dropped <= 1'b0;
    end else if (out_valid && out_ready) begin
      expect_pos  <= final_flag ? 5'd0 : position + 5'd1;
      set_dropped <= dropped;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_position_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position == expect_pos)
    else $error("result position out of sequence");

  a_dropped_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && expect_pos != 5'd0 |-> dropped == set_dropped)
    else $error("dropped flag changed within a set");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(position))
    else $error("stalled result changed");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .value      (value),
  .position   (position),
  .final_flag (final_flag),
  .dropped    (dropped)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

// Checks heap_sort_engine against an in-bench heapsort predictor. Sets of
// elements are sent over the input channel. Each set is processed when its
// element with set_end arrives. Every result transaction is compared with
// the oldest predicted result.
module tb_top;
  import hse_pkg::*;

  // The bench uses the default capacity of the engine.
  localparam int CAP = 32;

  // Values of the one-bit configuration registers.
  localparam logic MAX_HEAP   = 1'b0;
  localparam logic MIN_HEAP   = 1'b1;
  localparam logic ASCENDING  = 1'b0;
  localparam logic DESCENDING = 1'b1;
  localparam logic FULL_SORT  = 1'b0;
  localparam logic HEAP_ONLY  = 1'b1;

  // The only index that maps to no register. Writes to it must be ignored.
  localparam logic [1:0] REG_NONE = 2'd3;

  // Stimulus styles for element values.
  localparam int STYLE_WIDE    = 0;
  localparam int STYLE_NARROW  = 1;
  localparam int STYLE_EXTREME = 2;

  localparam logic signed [DATA_W-1:0] ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ELEM_MAX = ~ELEM_MIN;

  // A full sort of 32 elements runs with no transaction, and the receiver
  // may stall for long stretches. The limit covers both many times over.
  localparam int STALL_LIMIT   = 20000;
  // Pause before a register write, and at the end of the run.
  localparam int SETTLE_CYCLES = 16;
  // Minimum input items in each of the three idling phases of the random test.
  localparam int PHASE_ITEMS   = 55;

  // One result transaction as the engine presents it.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     final_flag;
    logic                     dropped;
  } sorted_out_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic signed [DATA_W-1:0] element   = '0;
  logic                     set_end   = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [1:0]               cfg_index = REG_HEAP_KIND;
  logic                     cfg_data  = 1'b0;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     cfg_ready;
  logic                     out_valid;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;
  logic                     final_flag;
  logic                     dropped;

  heap_sort_engine #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .element   (element),
    .set_end   (set_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .position  (position),
    .final_flag(final_flag),
    .dropped   (dropped)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Percent of cycles in which the sender and the receiver hold back.
  int src_idle_pct = 30;
  int snk_idle_pct = 83;

  int mismatches  = 0;
  int items_sent  = 0;
  int stall_count = 0;

  // Predictor state: the set being collected and the register settings.
  logic signed [DATA_W-1:0] set_store [CAP];
  int                       set_fill     = 0;
  logic                     set_overflow = 1'b0;
  logic                     cur_heap_kind  = MAX_HEAP;
  logic                     cur_sort_order = ASCENDING;
  logic                     cur_build_only = FULL_SORT;

  // Results predicted but not yet seen on the output channel, oldest first.
  sorted_out_t sorted_results [$];

  // True when a belongs nearer the root than b for the current heap kind.
  function automatic logic outranks(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
    return (cur_heap_kind == MIN_HEAP) ? (a < b) : (a > b);
  endfunction

  function automatic void swap_entries(input int i, input int j);
    logic signed [DATA_W-1:0] tmp;
    tmp          = set_store[i];
    set_store[i] = set_store[j];
    set_store[j] = tmp;
  endfunction

  // Moves the entry at root down until neither child outranks it. On a tie
  // the left child wins, since the right one must strictly outrank it.
  function automatic void sift_down(input int len, input int root);
    int   best;
    int   left;
    logic settled;
    settled = 1'b0;
    while (!settled && root < len) begin
      best = root;
      left = 2 * root + 1;
      if (left < len && outranks(set_store[left], set_store[best])) begin
        best = left;
      end
      if (left + 1 < len && outranks(set_store[left + 1], set_store[best])) begin
        best = left + 1;
      end
      if (best == root) begin
        settled = 1'b1;
      end else begin
        swap_entries(root, best);
        root = best;
      end
    end
  endfunction

  // Heapifies the collected set bottom-up, sorts it unless only the heap is
  // wanted, and queues one result per stored element.
  function automatic void predict_sorted_set();
    int          n;
    int          i;
    sorted_out_t res;
    n = set_fill;
    for (i = n / 2 - 1; i >= 0; i--) begin
      sift_down(n, i);
    end
    if (cur_build_only == FULL_SORT) begin
      for (i = n - 1; i > 0; i--) begin
        swap_entries(0, i);
        sift_down(i, 0);
      end
      // A max-heap leaves the set ascending and a min-heap descending.
      if (cur_heap_kind != cur_sort_order) begin
        for (i = 0; i < n / 2; i++) begin
          swap_entries(i, n - 1 - i);
        end
      end
    end
    for (i = 0; i < n; i++) begin
      res.value      = set_store[i];
      res.position   = i[POS_W-1:0];
      res.final_flag = (i == n - 1);
      res.dropped    = set_overflow;
      sorted_results.push_back(res);
    end
    set_fill     = 0;
    set_overflow = 1'b0;
  endfunction

  // Element of the given style. Narrow values collide often, so ties get
  // exercised in the heap.
  function automatic logic signed [DATA_W-1:0] pick_element(input int style);
    logic signed [DATA_W-1:0] e;
    case (style)
      STYLE_WIDE: begin
        e = $urandom;
      end
      STYLE_NARROW: begin
        e = int'($urandom_range(6)) - 3;
      end
      default: begin
        case ($urandom_range(5))
          0: e = ELEM_MIN;
          1: e = ELEM_MAX;
          2: e = '0;
          3: e = -1;
          4: e = ELEM_MIN + 1;
          default: e = ELEM_MAX - 1;
        endcase
      end
    endcase
    return e;
  endfunction

  // Sends one element. Valid is lowered only in idle cycles, so back-to-back
  // transactions keep it high without a drop in between.
  task automatic send_item(input logic signed [DATA_W-1:0] e, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    element  <= e;
    set_end  <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_sent++;
    // Store the element, or note the overflow once the set is full.
    if (set_fill < CAP) begin
      set_store[set_fill] = e;
      set_fill++;
    end else begin
      set_overflow = 1'b1;
    end
    if (last) begin
      predict_sorted_set();
    end
  endtask

  // A set of len elements, mostly of one style with some others mixed in.
  task automatic send_set(input int len, input int style);
    int k;
    for (k = 0; k < len; k++) begin
      send_item(pick_element(($urandom_range(4) == 0) ? int'($urandom_range(2)) : style),
                k == len - 1);
    end
  endtask

  // Stops input traffic and waits until every predicted result has arrived,
  // then lets the engine settle back to idle.
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (sorted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  // One register write. Valid stays high so that writes can follow each
  // other directly; the caller lowers it after the last one.
  task automatic cfg_write(input logic [1:0] idx, input logic data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_HEAP_KIND:  cur_heap_kind  = data;
      REG_SORT_ORDER: cur_sort_order = data;
      REG_BUILD_ONLY: cur_build_only = data;
      default: ;
    endcase
  endtask

  // Writes all three registers while the engine is idle, optionally followed
  // by a write to the unused index that must change nothing.
  task automatic apply_mode(input logic kind, input logic order, input logic heap_only,
                            input logic stray_write);
    wait_idle(SETTLE_CYCLES);
    cfg_write(REG_HEAP_KIND, kind);
    cfg_write(REG_SORT_ORDER, order);
    cfg_write(REG_BUILD_ONLY, heap_only);
    if (stray_write) begin
      cfg_write(REG_NONE, 1'($urandom_range(1)));
    end
    cfg_valid <= 1'b0;
  endtask

  // A single-element set at the lower field limit, then a small set that mixes
  // both limits with zero and minus one, under the settings from reset.
  task automatic test_extremes();
    send_item(ELEM_MIN, 1'b1);
    send_item(ELEM_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item(ELEM_MIN, 1'b0);
    send_item(-1, 1'b1);
  endtask

  // Every combination of heap kind, order and heap-only mode on a small set.
  // Odd combinations carry an extreme in the middle.
  task automatic test_modes();
    int mode;
    for (mode = 0; mode < 8; mode++) begin
      apply_mode(mode[0], mode[1], mode[2], mode == 3);
      send_item(-9, 1'b0);
      if (mode[0]) begin
        send_item(mode[1] ? ELEM_MAX : ELEM_MIN, 1'b0);
      end
      send_item(9, 1'b1);
    end
  endtask

  // Random sets in three idling phases. Each phase opens with a set at the
  // capacity edge, in phase order: exactly full, one over so that the
  // closing element is lost, then two over. Later sets are mostly short, with
  // a rare set near or beyond capacity. Settings change between sets now and then.
  task automatic test_random();
    int phase;
    int phase_start;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 30;
          snk_idle_pct = 83;
        end
        1: begin
          src_idle_pct = 83;
          snk_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      phase_start = items_sent;
      send_set(CAP + phase, $urandom_range(2));
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(2) == 0) begin
          apply_mode(1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), $urandom_range(3) == 0);
        end
        if ($urandom_range(9) == 0) begin
          send_set($urandom_range(CAP + 6, CAP - 3), $urandom_range(2));
        end else begin
          send_set($urandom_range(12, 1), $urandom_range(2));
        end
      end
    end
  endtask

  // Result checker and receiver. Out_ready is sampled before this edge's
  // update, so the check sees the ready that the engine saw.
  always @(posedge clk) begin : result_check
    sorted_out_t got;
    sorted_out_t want;
    if (!rst && out_valid && out_ready) begin
      got.value      = value;
      got.position   = position;
      got.final_flag = final_flag;
      got.dropped    = dropped;
      if (sorted_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: value=%0d position=%0d final=%0b dropped=%0b",
                 $time, got.value, got.position, got.final_flag, got.dropped);
      end else begin
        want = sorted_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: result mismatch: expected value=%0d position=%0d final=%0b dropped=%0b",
                   $time, want.value, want.position, want.final_flag, want.dropped);
          $display("%0t:                  actual value=%0d position=%0d final=%0b dropped=%0b",
                   $time, got.value, got.position, got.final_flag, got.dropped);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: ends the run when no channel has moved a transaction for too
  // long, which also catches results that never arrive.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_modes();
    test_random();
    wait_idle(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
